### hdl/iss_pkg.sv
package iss_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int SUM_WIDTH   = TIME_WIDTH + COUNT_WIDTH;
  localparam int FUNC_WIDTH  = 2;
  localparam int DIV_CNT_W   = $clog2(SUM_WIDTH);

  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_FILL_W  = $clog2(CMD_DEPTH + 1);

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_START  = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_RECORD = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    logic                  clear;
    logic                  keep;
    logic [TIME_WIDTH-1:0] span;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } back_state_t;

endpackage

### hdl/iss_front.sv
module iss_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [iss_pkg::FUNC_WIDTH-1:0]  func,
  input  logic [iss_pkg::TIME_WIDTH-1:0]  now_time,
  input  logic                            cmd_full,
  output logic                            cmd_write,
  output iss_pkg::cmd_t                   cmd
);
  import iss_pkg::*;

  logic [TIME_WIDTH-1:0] last_mark;
  logic [TIME_WIDTH-1:0] last_mark_next;
  logic                  mark_held;

  assign mark_held = (last_mark != '0);
  assign cmd_write = push && !cmd_full;

  always_comb begin
    last_mark_next = last_mark;
    cmd.clear      = 1'b0;
    cmd.keep       = 1'b0;
    cmd.span       = '0;
    case (func_t'(func))
      FUNC_START: begin
        last_mark_next = now_time;
      end
      FUNC_STOP: begin
        cmd.keep = mark_held;
      end
      FUNC_RECORD: begin
        if (mark_held) begin
          cmd.keep = 1'b1;
        end else begin
          last_mark_next = now_time;
        end
      end
      FUNC_CLEAR: begin
        cmd.clear      = 1'b1;
        last_mark_next = '0;
      end
      default: begin
        last_mark_next = last_mark;
      end
    endcase
    if (cmd.keep) begin
      cmd.span       = now_time - last_mark;
      last_mark_next = now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mark <= '0;
    end else if (cmd_write) begin
      last_mark <= last_mark_next;
    end
  end

endmodule

### hdl/iss_cmd_fifo.sv
module iss_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  iss_pkg::cmd_t wr_data,
  input  logic          rd,
  output iss_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import iss_pkg::*;

  cmd_t                  slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]  wr_ptr;
  logic [CMD_PTR_W-1:0]  rd_ptr;
  logic [CMD_FILL_W-1:0] fill;

  assign full    = (fill == CMD_FILL_W'(CMD_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/iss_back.sv
module iss_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             record_limit_we,
  input  logic [iss_pkg::LIMIT_WIDTH-1:0]  record_limit,
  input  logic                             cmd_empty,
  input  iss_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic [iss_pkg::TIME_WIDTH-1:0]   span_time,
  output logic [iss_pkg::COUNT_WIDTH-1:0]  span_count,
  output logic [iss_pkg::TIME_WIDTH-1:0]   biggest_span,
  output logic [iss_pkg::TIME_WIDTH-1:0]   shortest_span,
  output logic [iss_pkg::TIME_WIDTH-1:0]   average_span
);
  import iss_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [LIMIT_WIDTH-1:0] limit;
  logic [COUNT_WIDTH-1:0] kept_count;
  logic [SUM_WIDTH-1:0]   span_sum;
  logic [TIME_WIDTH-1:0]  max_span;
  logic [TIME_WIDTH-1:0]  min_span;
  logic [TIME_WIDTH-1:0]  span_hold;

  logic [SUM_WIDTH-1:0]   quo;
  logic [COUNT_WIDTH-1:0] rem;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   out_valid;

  logic                   load_div;
  logic                   div_step;
  logic                   load_out;
  logic                   div_last;
  logic                   keep_ok;
  logic [SUM_WIDTH:0]     sum_add;
  logic [COUNT_WIDTH:0]   shifted;
  logic                   bit_fits;

  assign empty    = !out_valid;
  assign div_last = (div_cnt == '0);
  assign keep_ok  = cmd.keep && !((limit != '0) && (kept_count >= limit));
  assign sum_add  = {1'b0, span_sum} + {{(COUNT_WIDTH + 1){1'b0}}, cmd.span};
  assign shifted  = {rem, quo[SUM_WIDTH-1]};
  assign bit_fits = (shifted >= {1'b0, kept_count});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!cmd_empty) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_last) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || pop) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    load_div = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:   cmd_pop  = !cmd_empty;
      ST_SETUP:  load_div = 1'b1;
      ST_DIVIDE: div_step = 1'b1;
      ST_FINISH: load_out = !out_valid || pop;
      default:   cmd_pop  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      limit      <= '0;
      kept_count <= '0;
      span_sum   <= '0;
      max_span   <= '0;
      min_span   <= '1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (record_limit_we) begin
        limit <= record_limit;
      end
      if (cmd_pop) begin
        if (cmd.clear) begin
          kept_count <= '0;
          span_sum   <= '0;
          max_span   <= '0;
          min_span   <= '1;
        end else if (keep_ok) begin
          if (kept_count != '1) begin
            kept_count <= kept_count + 1'b1;
          end
          span_sum <= sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
          if (cmd.span > max_span) begin
            max_span <= cmd.span;
          end
          if (cmd.span < min_span) begin
            min_span <= cmd.span;
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      span_hold <= cmd.span;
    end
    if (load_div) begin
      quo     <= span_sum;
      rem     <= '0;
      div_cnt <= DIV_CNT_W'(SUM_WIDTH - 1);
    end else if (div_step) begin
      quo     <= {quo[SUM_WIDTH-2:0], bit_fits};
      rem     <= bit_fits ? COUNT_WIDTH'(shifted - {1'b0, kept_count})
                          : shifted[COUNT_WIDTH-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
    if (load_out) begin
      span_time  <= span_hold;
      span_count <= kept_count;
      if (kept_count == '0) begin
        biggest_span  <= '0;
        shortest_span <= '0;
        average_span  <= '0;
      end else begin
        biggest_span  <= max_span;
        shortest_span <= min_span;
        average_span  <= quo[TIME_WIDTH-1:0];
      end
    end
  end

endmodule

### hdl/interval_span_statistics_top.sv
// Interval span statistics block.
// Events enter through a queue-style port: drive func and now_time with push high;
// the event is taken at a clock edge where full is low. Results leave the same way:
// while empty is low the oldest result is on the result ports, and it is taken at a
// clock edge where pop is high. Each event gives exactly one result transaction.
// The front end tracks the start mark and measures the span in the cycle the event
// is taken, then posts a command into a two-entry queue. The back end applies the
// command to the statistics and computes the average with a restoring divider that
// retires one quotient bit per cycle. For each event the back end pops the command,
// sets up the divider, runs the division and then loads the output register. The
// queue lets up to two more events be taken while the back end works.
// When the receiver stalls, the finished result waits in the output register and the
// back end holds its next result until that one is popped; the queue then fills and
// full rises. Reset clears the mark, the statistics, the queue, the valid flag of the
// output register and the record limit. The user must write the record limit with
// record_limit_we only while no event is in flight; the block does not enforce this.
module interval_span_statistics_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             record_limit_we,
  input  logic [iss_pkg::LIMIT_WIDTH-1:0]  record_limit,
  input  logic                             push,
  output logic                             full,
  input  logic [iss_pkg::FUNC_WIDTH-1:0]   func,
  input  logic [iss_pkg::TIME_WIDTH-1:0]   now_time,
  output logic                             empty,
  input  logic                             pop,
  output logic [iss_pkg::TIME_WIDTH-1:0]   span_time,
  output logic [iss_pkg::COUNT_WIDTH-1:0]  span_count,
  output logic [iss_pkg::TIME_WIDTH-1:0]   biggest_span,
  output logic [iss_pkg::TIME_WIDTH-1:0]   shortest_span,
  output logic [iss_pkg::TIME_WIDTH-1:0]   average_span
);
  import iss_pkg::*;

  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic cmd_write;
  logic cmd_pop;
  logic cmd_empty;

  iss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .func      (func),
    .now_time  (now_time),
    .cmd_full  (full),
    .cmd_write (cmd_write),
    .cmd       (wr_cmd)
  );

  iss_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_write),
    .wr_data (wr_cmd),
    .rd      (cmd_pop),
    .rd_data (rd_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  iss_back u_back (
    .clk             (clk),
    .rst             (rst),
    .record_limit_we (record_limit_we),
    .record_limit    (record_limit),
    .cmd_empty       (cmd_empty),
    .cmd             (rd_cmd),
    .cmd_pop         (cmd_pop),
    .pop             (pop),
    .empty           (empty),
    .span_time       (span_time),
    .span_count      (span_count),
    .biggest_span    (biggest_span),
    .shortest_span   (shortest_span),
    .average_span    (average_span)
  );

endmodule

### sim/interval_span_statistics_top_tb.sv
module interval_span_statistics_top_tb;
  import iss_pkg::*;

  typedef struct {
    func_t                 op;
    logic [TIME_WIDTH-1:0] stamp;
  } span_event_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  span;
    logic [COUNT_WIDTH-1:0] count;
    logic [TIME_WIDTH-1:0]  biggest;
    logic [TIME_WIDTH-1:0]  shortest;
    logic [TIME_WIDTH-1:0]  average;
  } span_report_t;

  localparam logic [SUM_WIDTH-1:0]   SUM_FULL   = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;
  localparam logic [TIME_WIDTH-1:0]  TIME_FULL  = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   record_limit_we = 1'b0;
  logic [LIMIT_WIDTH-1:0] record_limit = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [FUNC_WIDTH-1:0]  func = FUNC_START;
  logic [TIME_WIDTH-1:0]  now_time = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [TIME_WIDTH-1:0]  span_time;
  logic [COUNT_WIDTH-1:0] span_count;
  logic [TIME_WIDTH-1:0]  biggest_span;
  logic [TIME_WIDTH-1:0]  shortest_span;
  logic [TIME_WIDTH-1:0]  average_span;

  // Copy of the block's state used to predict each result.
  logic [TIME_WIDTH-1:0]  held_mark = '0;
  logic [COUNT_WIDTH-1:0] kept_spans = '0;
  logic [SUM_WIDTH-1:0]   span_total = '0;
  logic [TIME_WIDTH-1:0]  widest = '0;
  logic [TIME_WIDTH-1:0]  narrowest = '1;
  logic [LIMIT_WIDTH-1:0] limit_setting = '0;

  span_event_t  pending_events[$];
  span_report_t expected_reports[$];
  span_event_t  next_event;
  span_report_t want;

  int events_queued = 0;
  int events_taken = 0;
  int reports_taken = 0;
  int mismatches = 0;
  int send_wait = 0;
  int pop_wait = 0;
  bit no_idle = 1'b0;

  interval_span_statistics_top dut (
    .clk            (clk),
    .rst            (rst),
    .record_limit_we(record_limit_we),
    .record_limit   (record_limit),
    .push           (push),
    .full           (full),
    .func           (func),
    .now_time       (now_time),
    .empty          (empty),
    .pop            (pop),
    .span_time      (span_time),
    .span_count     (span_count),
    .biggest_span   (biggest_span),
    .shortest_span  (shortest_span),
    .average_span   (average_span)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic span_report_t advance_span_stats(func_t op, logic [TIME_WIDTH-1:0] now);
    span_report_t           r;
    logic [TIME_WIDTH-1:0]  span;
    logic [SUM_WIDTH-1:0]   quotient;
    bit                     measure;
    span = '0;
    measure = 1'b0;
    case (op)
      FUNC_START: begin
        held_mark = now;
      end
      FUNC_STOP: begin
        measure = (held_mark != '0);
      end
      FUNC_RECORD: begin
        if (held_mark != '0) measure = 1'b1;
        else held_mark = now;
      end
      default: begin
        held_mark = '0;
        kept_spans = '0;
        span_total = '0;
        widest = '0;
        narrowest = TIME_FULL;
      end
    endcase
    if (measure) begin
      span = now - held_mark;
      if (!(limit_setting != '0 && kept_spans >= limit_setting)) begin
        if (kept_spans != COUNT_FULL) kept_spans++;
        if ({{COUNT_WIDTH{1'b0}}, span} > SUM_FULL - span_total) span_total = SUM_FULL;
        else span_total = span_total + {{COUNT_WIDTH{1'b0}}, span};
        if (span > widest) widest = span;
        if (span < narrowest) narrowest = span;
      end
      held_mark = now;
    end
    r.span = span;
    r.count = kept_spans;
    if (kept_spans == '0) begin
      r.biggest = '0;
      r.shortest = '0;
      r.average = '0;
    end else begin
      quotient = span_total / {{TIME_WIDTH{1'b0}}, kept_spans};
      r.biggest = widest;
      r.shortest = narrowest;
      r.average = quotient[TIME_WIDTH-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_reports.insert(expected_reports.size(),
                                advance_span_stats(func_t'(func), now_time));
        events_taken++;
        send_wait = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (pending_events.size() != 0) begin
        next_event = pending_events.pop_front();
        func <= next_event.op;
        now_time <= next_event.stamp;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, span_time %h", $time, span_time);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (span_time !== want.span) begin
            $display("%0t: span_time expected %h actual %h", $time, want.span, span_time);
            mismatches++;
          end
          if (span_count !== want.count) begin
            $display("%0t: span_count expected %h actual %h", $time, want.count, span_count);
            mismatches++;
          end
          if (biggest_span !== want.biggest) begin
            $display("%0t: biggest_span expected %h actual %h", $time, want.biggest,
                     biggest_span);
            mismatches++;
          end
          if (shortest_span !== want.shortest) begin
            $display("%0t: shortest_span expected %h actual %h", $time, want.shortest,
                     shortest_span);
            mismatches++;
          end
          if (average_span !== want.average) begin
            $display("%0t: average_span expected %h actual %h", $time, want.average,
                     average_span);
            mismatches++;
          end
        end
        reports_taken++;
        // A long hold-off lets the input side fill the block until it stalls.
        if (reports_taken == 300 || reports_taken == 1000) pop_wait = 800;
        else pop_wait = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_event(func_t op, logic [TIME_WIDTH-1:0] stamp);
    span_event_t ev;
    ev.op = op;
    ev.stamp = stamp;
    pending_events.insert(pending_events.size(), ev);
    events_queued++;
  endtask

  task automatic wait_for_drain();
    while (events_taken != events_queued || expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_record_limit(logic [LIMIT_WIDTH-1:0] value);
    @(posedge clk);
    record_limit_we <= 1'b1;
    record_limit <= value;
    @(posedge clk);
    record_limit_we <= 1'b0;
    limit_setting = value;
  endtask

  task automatic queue_random_events(int n);
    int                    made;
    int                    runs;
    logic [TIME_WIDTH-1:0] t;
    logic [TIME_WIDTH-1:0] step;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0: begin
          add_event(FUNC_CLEAR, $urandom());
          made++;
        end
        1: begin
          add_event(func_t'($urandom_range(0, 3)), $urandom());
          made++;
        end
        default: begin
          t = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
          add_event(($urandom_range(0, 1) == 0) ? FUNC_START : FUNC_RECORD, t);
          made++;
          runs = $urandom_range(1, 8);
          repeat (runs) begin
            case ($urandom_range(0, 9))
              0: step = $urandom();
              1: step = '0;
              default: step = $urandom_range(1, 5000);
            endcase
            t = t + step;
            add_event(($urandom_range(0, 1) == 0) ? FUNC_STOP : FUNC_RECORD, t);
            made++;
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [LIMIT_WIDTH-1:0] limits[7];
    limits = '{16'hFFFF, 16'd3, 16'd0, 16'd1, 16'd17, 16'd0, 16'd5};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_record_limit(16'd0);
    add_event(FUNC_STOP, 32'h0000_1234);
    add_event(FUNC_RECORD, 32'h0000_0000);
    add_event(FUNC_START, 32'h0000_0000);
    add_event(FUNC_STOP, 32'h0000_0032);
    add_event(FUNC_RECORD, 32'h0000_0064);
    add_event(FUNC_START, 32'h0000_00C8);
    add_event(FUNC_STOP, 32'hFFFF_FFFF);
    add_event(FUNC_RECORD, 32'h0000_0005);
    add_event(FUNC_STOP, 32'h0000_0005);
    add_event(FUNC_CLEAR, 32'hFFFF_FFFF);
    add_event(FUNC_STOP, 32'h0000_0009);
    add_event(FUNC_START, 32'hFFFF_FFFF);
    add_event(FUNC_STOP, 32'h0000_0000);
    add_event(FUNC_RECORD, 32'h0000_0007);
    add_event(FUNC_CLEAR, 32'h0000_0000);
    wait_for_drain();

    set_record_limit(16'd1);
    add_event(FUNC_START, 32'h0000_000A);
    add_event(FUNC_STOP, 32'h0000_0014);
    add_event(FUNC_STOP, 32'h0000_002D);
    add_event(FUNC_RECORD, 32'h0000_003C);
    add_event(FUNC_CLEAR, 32'h0000_0003);
    add_event(FUNC_RECORD, 32'h5555_AAAA);
    add_event(FUNC_STOP, 32'hAAAA_5555);
    wait_for_drain();

    for (int p = 0; p < 7; p++) begin
      set_record_limit(limits[p]);
      no_idle = (p == 2 || p == 5);
      queue_random_events(220);
      wait_for_drain();
    end
    no_idle = 1'b0;

    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
